// ===== src/bal_pkg.sv =====
// Shared command codes, cell operation codes and cell control type for the array list engine.
package bal_pkg;

	localparam logic [2:0] CMD_APPEND  = 3'd0;
	localparam logic [2:0] CMD_INSERT  = 3'd1;
	localparam logic [2:0] CMD_DELETE  = 3'd2;
	localparam logic [2:0] CMD_GET     = 3'd3;
	localparam logic [2:0] CMD_SORT    = 3'd4;
	localparam logic [2:0] CMD_REVERSE = 3'd5;

	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_SORT   = 3'd4;
	localparam logic [2:0] OP_REV    = 3'd5;

	localparam int WORD_W  = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [2:0] op;
		logic       phase;
	} ctl_t;

endpackage

// ===== src/bounded_array_list_engine_core.sv =====
// Top level of the bounded array list engine: command decode, cell row and result register.
//
// Requests enter on in_valid/in_stall with cmd, position and value; each request
// produces exactly one result on out_valid/out_stall with ok, read_data and count.
// The list lives in a row of CAPACITY cells; each cell holds one word and trades it
// only with its two neighbors.
// Append, insert, delete and get finish in the cycle they are accepted: the result
// is registered and shows in the next cycle, and one such request can be accepted
// every cycle while the receiver takes each result.
// Sort and reverse run odd-even transposition rounds over the row, one round per
// cycle, held rounds in all, then load the result once the result register is free;
// in_stall stays high from the request until the result is loaded.
// When the receiver stalls, the result register holds its request and in_stall
// rises so that no further request is taken until the result is taken.
// Reset empties the list (length 0) and drops any pending result; cell contents are
// not cleared, and only words below count are ever read.
module bounded_array_list_engine_core #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        cmd,
	input  logic [bal_pkg::POS_W-1:0]         position,
	input  logic signed [bal_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic signed [bal_pkg::WORD_W-1:0] read_data,
	output logic [bal_pkg::COUNT_W-1:0]       count
);
	import bal_pkg::*;

	localparam int HW = $clog2(CAPACITY + 1);
	localparam int CW = ((HW > POS_W) ? HW : POS_W) + 1;
	localparam logic [HW-1:0] CAP_H = HW'(CAPACITY);

	logic [HW-1:0]      held_q;
	logic [HW-1:0]      held_d;
	logic [HW-1:0]      rounds_q;
	logic [HW-1:0]      rounds_d;
	logic               busy_q;
	logic               busy_d;
	logic               rev_q;
	logic               rev_d;
	logic               out_valid_q;
	logic               ok_q;
	logic [WORD_W-1:0]  rd_q;
	logic [COUNT_W-1:0] count_q;

	logic               out_free;
	logic               accept;
	logic               full;
	logic [CW-1:0]      pos_w;
	logic [CW-1:0]      held_w;
	ctl_t               ctl;
	logic               res_load;
	logic               res_ok;
	logic [WORD_W-1:0]  res_rd;
	logic [WORD_W-1:0]  hit_or;

	logic [WORD_W-1:0]  cell_data [CAPACITY];
	logic [WORD_W-1:0]  cell_hit  [CAPACITY];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy_q || !out_free;
	assign accept   = in_valid && !in_stall;
	assign full     = (held_q == CAP_H);
	assign pos_w    = CW'(position);
	assign held_w   = CW'(held_q);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [WORD_W-1:0] lft;
			logic [WORD_W-1:0] rgt;
			if (gi == 0) begin : g_first
				assign lft = '0;
			end else begin : g_mid_l
				assign lft = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rgt = '0;
			end else begin : g_mid_r
				assign rgt = cell_data[gi+1];
			end
			bal_cell #(
				.CW  (CW),
				.IDX (gi)
			) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.pos   (pos_w),
				.held  (held_w),
				.value (value),
				.left  (lft),
				.right (rgt),
				.data  (cell_data[gi]),
				.hit   (cell_hit[gi])
			);
		end
	endgenerate

	always_comb begin
		hit_or = '0;
		for (int k = 0; k < CAPACITY; k++)
			hit_or = hit_or | cell_hit[k];
	end

	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.phase = rounds_q[0];
		res_load  = 1'b0;
		res_ok    = 1'b0;
		res_rd    = '1;
		held_d    = held_q;
		rounds_d  = rounds_q;
		busy_d    = busy_q;
		rev_d     = rev_q;
		if (busy_q) begin
			if (rounds_q != held_q) begin
				ctl.op   = rev_q ? OP_REV : OP_SORT;
				rounds_d = rounds_q + 1'b1;
			end else if (out_free) begin
				res_load = 1'b1;
				res_ok   = 1'b1;
				res_rd   = '0;
				busy_d   = 1'b0;
			end
		end else if (accept) begin
			res_load = 1'b1;
			case (cmd)
				CMD_APPEND: begin
					if (!full) begin
						ctl.op = OP_APPEND;
						held_d = held_q + 1'b1;
						res_ok = 1'b1;
						res_rd = '0;
					end
				end
				CMD_INSERT: begin
					if (!full && pos_w <= held_w) begin
						ctl.op = OP_INSERT;
						held_d = held_q + 1'b1;
						res_ok = 1'b1;
						res_rd = '0;
					end
				end
				CMD_DELETE: begin
					if (pos_w < held_w) begin
						ctl.op = OP_DELETE;
						held_d = held_q - 1'b1;
						res_ok = 1'b1;
						res_rd = '0;
					end
				end
				CMD_GET: begin
					if (pos_w < held_w) begin
						res_ok = 1'b1;
						res_rd = hit_or;
					end
				end
				CMD_SORT, CMD_REVERSE: begin
					// hold the result until all transposition rounds are done
					res_load = 1'b0;
					busy_d   = 1'b1;
					rounds_d = '0;
					rev_d    = (cmd == CMD_REVERSE);
				end
				default: begin
					res_ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			rounds_q    <= '0;
			busy_q      <= 1'b0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			held_q   <= held_d;
			rounds_q <= rounds_d;
			busy_q   <= busy_d;
			rev_q    <= rev_d;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			ok_q    <= res_ok;
			rd_q    <= res_rd;
			count_q <= COUNT_W'(held_d);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign read_data = rd_q;
	assign count     = count_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CAP_H)
		else $error("list length above capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_APPEND && !full) |=> held_q == $past(held_q) + 1'b1)
		else $error("append did not grow the list");

	a_rounds_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rounds_q <= held_q)
		else $error("transposition round count overran the list");

	a_refused_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> read_data == '1)
		else $error("refused request without all-ones read data");

endmodule

// ===== src/bal_cell.sv =====
// One list cell: holds a word and trades it with its neighbors on shift and transposition rounds.
module bal_cell #(
	parameter int CW  = 8,
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  bal_pkg::ctl_t              ctl,
	input  logic [CW-1:0]              pos,
	input  logic [CW-1:0]              held,
	input  logic [bal_pkg::WORD_W-1:0] value,
	input  logic [bal_pkg::WORD_W-1:0] left,
	input  logic [bal_pkg::WORD_W-1:0] right,
	output logic [bal_pkg::WORD_W-1:0] data,
	output logic [bal_pkg::WORD_W-1:0] hit
);
	import bal_pkg::*;

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);
	localparam logic          PARITY  = 1'(IDX % 2);

	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] data_d;
	logic              pair_right;
	logic              pair_left;
	logic              rev;

	assign rev        = (ctl.op == OP_REV);
	assign pair_right = (ctl.phase == PARITY) && (NXT_IDX < held);
	assign pair_left  = (ctl.phase != PARITY) && (IDX >= 1) && (MY_IDX < held);

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			OP_APPEND: begin
				if (MY_IDX == held)
					data_d = value;
			end
			OP_INSERT: begin
				if (MY_IDX == pos)
					data_d = value;
				else if (MY_IDX > pos && MY_IDX <= held)
					data_d = left;
			end
			OP_DELETE: begin
				if (MY_IDX >= pos && NXT_IDX < held)
					data_d = right;
			end
			OP_SORT, OP_REV: begin
				// swap with the partner of this round when reversing or out of order
				if (pair_right && (rev || ($signed(data_q) > $signed(right))))
					data_d = right;
				else if (pair_left && (rev || ($signed(left) > $signed(data_q))))
					data_d = left;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign hit  = (MY_IDX == pos) ? data_q : '0;

endmodule
